>>> hw/rtl/tlfq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlfq_pkg
// Shared types and codes of the three-level feedback queue scheduler.
// ----------------------------------------------------------------------------
package tlfq_pkg;

	localparam int DATA_W    = 16;
	localparam int ID_W      = 3;
	localparam int LVL_W     = 2;
	localparam int CMD_W     = 2;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_GRANT = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_ONE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_TWO   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_THREE = 2'd2;

	localparam logic [DATA_W-1:0] QUANTUM_ONE_RST   = 16'd5;
	localparam logic [DATA_W-1:0] QUANTUM_TWO_RST   = 16'd8;
	localparam logic [DATA_W-1:0] QUANTUM_THREE_RST = 16'd16;

	localparam logic [1:0] PH_FIRST    = 2'd0;
	localparam logic [1:0] PH_SECOND_A = 2'd1;
	localparam logic [1:0] PH_SECOND_B = 2'd2;
	localparam logic [1:0] PH_THIRD    = 2'd3;

	localparam logic [LVL_W-1:0] LVL_ONE   = 2'd1;
	localparam logic [LVL_W-1:0] LVL_TWO   = 2'd2;
	localparam logic [LVL_W-1:0] LVL_THREE = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [DATA_W-1:0] arrival_time;
		logic [DATA_W-1:0] burst_time;
	} in_word_t;

	typedef struct packed {
		logic              event_valid;
		logic [ID_W-1:0]   process_id;
		logic [LVL_W-1:0]  queue_level;
		logic [DATA_W-1:0] remaining_burst;
		logic              completed;
		logic              all_done;
		logic              table_full;
	} out_word_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [DATA_W-1:0] arrival;
		logic [DATA_W-1:0] remaining;
	} entry_t;

endpackage
`default_nettype wire

>>> hw/rtl/tlfq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlfq_ram
// Generic simple dual-port RAM: one write port, one read port with registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module tlfq_ram #(
	parameter int WIDTH = 35,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

>>> hw/rtl/three_level_feedback_queue_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_level_feedback_queue_scheduler
// Process table kept in arrival order, served by a three-level feedback
// queue: one pass at the first quantum, two passes at the second, then
// repeated passes at the third until every burst is spent.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Word
// in        input      in_valid / in_stall  tlfq_pkg::in_word_t (command, arrival, burst)
// out       output     out_valid / out_stall tlfq_pkg::out_word_t (one per command)
// cfg       input      cfg_valid / cfg_ready index and 16-bit quantum, ready always high
//
// A grant, a clear, an unused command and a dropped load pass the accept step
// and then the table RAM read or the result step. A load, after the accept
// step, moves up each table entry that must make room, since the insertion
// walks the RAM one entry a cycle, and then writes the new entry. The result
// word is registered and shows in the cycle after the last step.
// Reset clears the count, the phase, the scan position and the active flags at
// once; the table RAM needs no clearing pass. While the output word is stalled
// the block finishes its current command only when the output register frees,
// but a new input word is taken as soon as the previous result is registered.
//
module three_level_feedback_queue_scheduler #(
	parameter int MAX_PROCESSES = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire tlfq_pkg::in_word_t                  in_word,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output tlfq_pkg::out_word_t                      out_word,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [tlfq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [tlfq_pkg::DATA_W-1:0]         cfg_data
);

	import tlfq_pkg::*;

	localparam int IW = $clog2(MAX_PROCESSES);
	localparam int CW = $clog2(MAX_PROCESSES + 1);
	localparam int EW = $bits(entry_t);
	localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_PROCESSES);

	// Sequencer states.
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_LOAD  = 5'b00010,
		S_LDWR  = 5'b00100,
		S_GRANT = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// Control state. An active flag marks a table entry with burst left; flags
	// at and above the count are always zero.
	logic [CW-1:0]            count_q, count_d;
	logic [1:0]               phase_q, phase_d;
	logic [CW-1:0]            scan_q, scan_d;
	logic [MAX_PROCESSES-1:0] active_q, active_d;
	logic                     full_q, full_d;
	logic                     out_valid_q;

	// Per-command working registers.
	logic [IW-1:0]     pos_q, pos_d;
	logic [IW-1:0]     k_q, k_d;
	logic [LVL_W-1:0]  level_q, level_d;
	logic [DATA_W-1:0] at_q, at_d;
	logic [DATA_W-1:0] bt_q, bt_d;
	out_word_t         out_q;

	// Quantum registers.
	logic [DATA_W-1:0] quantum_one_q, quantum_two_q, quantum_three_q;

	// Table RAM.
	logic          ram_we, ram_re;
	logic [IW-1:0] ram_waddr, ram_raddr;
	entry_t        ram_wdata, ram_rdata;
	logic [EW-1:0] ram_rdata_raw;

	tlfq_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_PROCESSES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata_raw)
	);

	assign ram_rdata = entry_t'(ram_rdata_raw);

	// The output register is free when it is empty or being taken this cycle.
	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// Next live entry of the pass. When nothing is left at or after the scan
	// position the pass ends, the phase advances unless it is already the third,
	// and the search restarts at the front of the table.
	logic [MAX_PROCESSES-1:0] scan_mask, sel_hi;
	logic [IW-1:0]            pick_hi, pick_any, pick;
	logic                     found_hi;
	logic [1:0]               phase_next;
	logic [LVL_W-1:0]         level_next;

	always_comb begin
		pick_hi  = '0;
		pick_any = '0;
		for (int i = 0; i < MAX_PROCESSES; i++) begin
			scan_mask[i] = (CW'(i) >= scan_q);
		end
		sel_hi   = active_q & scan_mask;
		found_hi = |sel_hi;
		for (int i = MAX_PROCESSES - 1; i >= 0; i--) begin
			if (sel_hi[i]) begin
				pick_hi = IW'(i);
			end
			if (active_q[i]) begin
				pick_any = IW'(i);
			end
		end
		pick = found_hi ? pick_hi : pick_any;
		if (found_hi || (phase_q == PH_THIRD)) begin
			phase_next = phase_q;
		end else begin
			phase_next = phase_q + 2'd1;
		end
		unique case (phase_next)
			PH_FIRST:                 level_next = LVL_ONE;
			PH_SECOND_A, PH_SECOND_B: level_next = LVL_TWO;
			default:                  level_next = LVL_THREE;
		endcase
	end

	// Slice arithmetic for the entry read in the grant step. A quantum of zero
	// acts as one.
	logic [DATA_W-1:0] quantum_raw, quantum_eff, rem_next;
	logic              slice_done;

	always_comb begin
		unique case (level_q)
			LVL_ONE: quantum_raw = quantum_one_q;
			LVL_TWO: quantum_raw = quantum_two_q;
			default: quantum_raw = quantum_three_q;
		endcase
		quantum_eff = (quantum_raw == '0) ? DATA_W'(1) : quantum_raw;
		slice_done  = (ram_rdata.remaining <= quantum_eff);
		rem_next    = slice_done ? '0 : (ram_rdata.remaining - quantum_eff);
	end

	// Insertion of a loaded entry: flags below the landing position stay,
	// the new flag goes in, and the flags above move up by one.
	logic                     ins_do;
	logic [IW-1:0]            ins_pos;
	entry_t                   ins_entry;
	logic [MAX_PROCESSES-1:0] act_shift;
	out_word_t                res;
	logic                     out_load;

	assign act_shift = {active_q[MAX_PROCESSES-2:0], 1'b0};

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		phase_d   = phase_q;
		scan_d    = scan_q;
		active_d  = active_q;
		full_d    = full_q;
		pos_d     = pos_q;
		k_d       = k_q;
		level_d   = level_q;
		at_d      = at_q;
		bt_d      = bt_q;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		ins_do    = 1'b0;
		ins_pos   = pos_q;
		ins_entry = '{id: ID_W'(count_q), arrival: at_q, remaining: bt_q};
		out_load  = 1'b0;
		res       = '0;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					at_d   = in_word.arrival_time;
					bt_d   = in_word.burst_time;
					full_d = 1'b0;
					unique case (in_word.command)
						CMD_CLEAR: begin
							count_d  = '0;
							phase_d  = PH_FIRST;
							scan_d   = '0;
							active_d = '0;
							state_d  = S_RESP;
						end
						CMD_LOAD: begin
							if (count_q == FULL_COUNT) begin
								full_d  = 1'b1;
								state_d = S_RESP;
							end else if (count_q == '0) begin
								// Empty table: the entry lands at the front at once.
								ins_do    = 1'b1;
								ins_pos   = '0;
								ins_entry = '{id: ID_W'(count_q),
									arrival: in_word.arrival_time,
									remaining: in_word.burst_time};
								state_d   = S_RESP;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = IW'(count_q - CW'(1));
								pos_d     = IW'(count_q);
								state_d   = S_LOAD;
							end
						end
						CMD_GRANT: begin
							if (|active_q) begin
								ram_re    = 1'b1;
								ram_raddr = pick;
								k_d       = pick;
								phase_d   = phase_next;
								level_d   = level_next;
								scan_d    = CW'(pick) + CW'(1);
								state_d   = S_GRANT;
							end else begin
								state_d = S_RESP;
							end
						end
						default: begin
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_LOAD: begin
				// The read data is the entry just below pos_q.
				if (ram_rdata.arrival > at_q) begin
					ram_we    = 1'b1;
					ram_waddr = pos_q;
					ram_wdata = ram_rdata;
					pos_d     = pos_q - IW'(1);
					if (pos_q == IW'(1)) begin
						state_d = S_LDWR;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = pos_q - IW'(2);
					end
				end else if (out_free) begin
					ins_do   = 1'b1;
					ins_pos  = pos_q;
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_LDWR: begin
				if (out_free) begin
					ins_do   = 1'b1;
					ins_pos  = pos_q;
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_GRANT: begin
				if (out_free) begin
					ram_we    = 1'b1;
					ram_waddr = k_q;
					ram_wdata = '{id: ram_rdata.id, arrival: ram_rdata.arrival,
						remaining: rem_next};
					if (slice_done) begin
						active_d[k_q] = 1'b0;
					end
					res.event_valid     = 1'b1;
					res.process_id      = ram_rdata.id;
					res.queue_level     = level_q;
					res.remaining_burst = rem_next;
					res.completed       = slice_done;
					out_load            = 1'b1;
					state_d             = S_IDLE;
				end
			end
			S_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (ins_do) begin
			ram_we    = 1'b1;
			ram_waddr = ins_pos;
			ram_wdata = ins_entry;
			count_d   = count_q + CW'(1);
			for (int i = 0; i < MAX_PROCESSES; i++) begin
				if (IW'(i) < ins_pos) begin
					active_d[i] = active_q[i];
				end else if (IW'(i) == ins_pos) begin
					active_d[i] = (ins_entry.remaining != '0);
				end else begin
					active_d[i] = act_shift[i];
				end
			end
		end

		// The done flag reflects the table after the command.
		res.all_done   = !(|active_d);
		res.table_full = full_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			phase_q     <= PH_FIRST;
			scan_q      <= '0;
			active_q    <= '0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			phase_q  <= phase_d;
			scan_q   <= scan_d;
			active_q <= active_d;
			full_q   <= full_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q   <= pos_d;
		k_q     <= k_d;
		level_q <= level_d;
		at_q    <= at_d;
		bt_q    <= bt_d;
		if (out_load) begin
			out_q <= res;
		end
	end

	// Quantum registers; writes to an index beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_one_q   <= QUANTUM_ONE_RST;
			quantum_two_q   <= QUANTUM_TWO_RST;
			quantum_three_q <= QUANTUM_THREE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_QUANTUM_ONE:   quantum_one_q   <= cfg_data;
				CFG_QUANTUM_TWO:   quantum_two_q   <= cfg_data;
				CFG_QUANTUM_THREE: quantum_three_q <= cfg_data;
				default:           ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule
`default_nettype wire

>>> hw/rtl/tlfq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlfq_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module tlfq_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_stall,
	input wire tlfq_pkg::in_word_t   in_word,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire tlfq_pkg::out_word_t  out_word
);

	import tlfq_pkg::*;

	// A stalled result word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	// Commands are handled one at a time: after an accept the input stalls.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while a command was in progress");

	// A new result word only appears while a command was in progress.
	a_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result word without a command in progress");

	// A granted slice never reports a dropped load and names a real level.
	a_grant_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.event_valid |->
			!out_word.table_full && (out_word.queue_level != '0))
		else $error("inconsistent grant word");

endmodule

bind three_level_feedback_queue_scheduler tlfq_checker u_tlfq_checker (.*);
`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the three-level feedback queue scheduler. A queue
// of command words feeds a clocked driver, and a clocked monitor checks each
// result word against a scheduler model kept in the bench. The run goes
// through several quantum settings and idling patterns.
// ----------------------------------------------------------------------------
module testbench;

	import tlfq_pkg::*;

	localparam int MAX_PROCS = 8;

	// Longest hold-off of the receiver, in cycles, used once to fill the block.
	localparam int HOLD_CYCLES = 300;

	// Cycles to let pass after the last result before a register write or the
	// end of the run; this outlasts a load that walks the whole table.
	localparam int SETTLE_CYCLES = 16;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_word_t  in_word = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_word_t out_word;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]    cfg_data = '0;

	three_level_feedback_queue_scheduler #(
		.MAX_PROCESSES(MAX_PROCS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Command words waiting for the driver, and the result words the model
	// has worked out for every command word the block has accepted.
	in_word_t  pending_words[$];
	out_word_t expected_slices[$];

	int unsigned failures = 0;
	int unsigned items_queued = 0;
	int unsigned sender_idle_pct = 7;
	int unsigned receiver_idle_pct = 51;
	bit          word_taken = 1'b0;
	bit          hold_request = 1'b0;
	int unsigned hold_left = 0;

	// Scheduler model: the process table in arrival order, the fill count,
	// the pass the scan is in and the next position the scan looks at.
	entry_t            proc_slots[MAX_PROCS];
	int unsigned       proc_count = 0;
	logic [1:0]        sched_phase = PH_FIRST;
	int unsigned       scan_pos = 0;
	logic [DATA_W-1:0] quantum_one = QUANTUM_ONE_RST;
	logic [DATA_W-1:0] quantum_two = QUANTUM_TWO_RST;
	logic [DATA_W-1:0] quantum_three = QUANTUM_THREE_RST;

	initial begin
		forever #5 clk = ~clk;
	end

	// Reset is held and then released on a falling edge, so that the first
	// clocked sample of the bench sees the block out of reset.
	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	// True while some loaded process still has burst left.
	function automatic bit work_left();
		int unsigned k;
		for (k = 0; k < proc_count; k++)
			if (proc_slots[k].remaining != 0)
				return 1'b1;
		return 1'b0;
	endfunction

	// Applies one command word to the model and returns the result word the
	// block has to give for it.
	function automatic out_word_t predict_slice(input in_word_t w);
		out_word_t         r;
		int unsigned       pos;
		int unsigned       k;
		logic [DATA_W-1:0] q;
		logic [LVL_W-1:0]  lvl;
		bit                found;
		r = '0;
		case (cmd_t'(w.command))
			CMD_CLEAR: begin
				proc_count = 0;
				sched_phase = PH_FIRST;
				scan_pos = 0;
			end
			CMD_LOAD: begin
				if (proc_count >= MAX_PROCS) begin
					r.table_full = 1'b1;
				end else begin
					// Insertion sort step: later arrivals move up one slot, equal
					// arrivals stay ahead so that load order breaks ties.
					pos = proc_count;
					while (pos > 0 && proc_slots[pos-1].arrival > w.arrival_time) begin
						proc_slots[pos] = proc_slots[pos-1];
						pos--;
					end
					proc_slots[pos].id = ID_W'(proc_count);
					proc_slots[pos].arrival = w.arrival_time;
					proc_slots[pos].remaining = w.burst_time;
					proc_count++;
				end
			end
			CMD_GRANT: begin
				if (work_left()) begin
					found = 1'b0;
					while (!found) begin
						k = scan_pos;
						while (k < proc_count && proc_slots[k].remaining == 0)
							k++;
						if (k < proc_count) begin
							case (sched_phase)
								PH_FIRST: begin
									lvl = LVL_ONE;
									q = quantum_one;
								end
								PH_SECOND_A, PH_SECOND_B: begin
									lvl = LVL_TWO;
									q = quantum_two;
								end
								default: begin
									lvl = LVL_THREE;
									q = quantum_three;
								end
							endcase
							// A quantum register holding zero grants one unit.
							if (q == 0)
								q = DATA_W'(1);
							if (proc_slots[k].remaining <= q) begin
								proc_slots[k].remaining = '0;
								r.completed = 1'b1;
							end else begin
								proc_slots[k].remaining = proc_slots[k].remaining - q;
							end
							r.event_valid = 1'b1;
							r.process_id = proc_slots[k].id;
							r.queue_level = lvl;
							r.remaining_burst = proc_slots[k].remaining;
							scan_pos = k + 1;
							found = 1'b1;
						end else begin
							// End of the table: the next pass starts, and the third
							// level repeats for as long as anything is left.
							if (sched_phase != PH_THIRD)
								sched_phase = sched_phase + 1'b1;
							scan_pos = 0;
						end
					end
				end
			end
			default: ;
		endcase
		r.all_done = !work_left();
		return r;
	endfunction

	task automatic compare_slice(input out_word_t exp, input out_word_t act);
		if (act.event_valid !== exp.event_valid) begin
			$error("event_valid: expected %0d, actual %0d", exp.event_valid, act.event_valid);
			failures++;
		end
		if (act.process_id !== exp.process_id) begin
			$error("process_id: expected %0d, actual %0d", exp.process_id, act.process_id);
			failures++;
		end
		if (act.queue_level !== exp.queue_level) begin
			$error("queue_level: expected %0d, actual %0d", exp.queue_level, act.queue_level);
			failures++;
		end
		if (act.remaining_burst !== exp.remaining_burst) begin
			$error("remaining_burst: expected %0d, actual %0d",
				exp.remaining_burst, act.remaining_burst);
			failures++;
		end
		if (act.completed !== exp.completed) begin
			$error("completed: expected %0d, actual %0d", exp.completed, act.completed);
			failures++;
		end
		if (act.all_done !== exp.all_done) begin
			$error("all_done: expected %0d, actual %0d", exp.all_done, act.all_done);
			failures++;
		end
		if (act.table_full !== exp.table_full) begin
			$error("table_full: expected %0d, actual %0d", exp.table_full, act.table_full);
			failures++;
		end
	endtask

	// Monitor. Both channels are sampled on the rising edge. An accepted
	// command word is run through the model at once, so the model sees the
	// words in the order the block takes them.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				word_taken = 1'b1;
				expected_slices.push_back(predict_slice(in_word));
			end
			if (out_valid && !out_stall) begin
				if (expected_slices.size() == 0) begin
					$error("out_word: no result expected, got %h", out_word);
					failures++;
				end else begin
					compare_slice(expected_slices.pop_front(), out_word);
				end
			end
		end
	end

	// Driver. A word stays on the bus until it has been taken; only then is
	// the next one fetched, or a gap cycle inserted at the sender's rate.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || word_taken) begin
				word_taken = 1'b0;
				if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					in_word <= pending_words.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver. Stalls at random at its own rate, and on request holds the
	// output off for a long stretch so that the block backs up into its input.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
			end
		end
	end

	task automatic queue_item(input cmd_t cmd, input int unsigned arr, input int unsigned burst);
		in_word_t w;
		w.command = cmd;
		w.arrival_time = DATA_W'(arr);
		w.burst_time = DATA_W'(burst);
		pending_words.push_back(w);
		// Unused commands change nothing and are not counted as stimulus.
		if (cmd != CMD_NONE)
			items_queued++;
	endtask

	// One scheduling run: mostly a clear, a table of loads, and enough grants
	// to walk through the levels, with the odd load arriving mid-run. Bursts
	// are sized against the current quanta so most runs drain completely.
	task automatic queue_schedule_run();
		int unsigned loads;
		int unsigned grants;
		int unsigned cap;
		int unsigned q1;
		int unsigned q2;
		int unsigned q3;
		int unsigned n;
		q1 = (quantum_one == 0) ? 1 : quantum_one;
		q2 = (quantum_two == 0) ? 1 : quantum_two;
		q3 = (quantum_three == 0) ? 1 : quantum_three;
		cap = q1 + 2 * q2 + 2 * q3;
		if (cap > 65535)
			cap = 65535;
		loads = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_PROCS + 1, MAX_PROCS + 2)
			: $urandom_range(1, MAX_PROCS);
		grants = loads * $urandom_range(2, 5) + $urandom_range(0, 2);
		if ($urandom_range(0, 9) != 0)
			queue_item(CMD_CLEAR, $urandom, $urandom);
		for (n = 0; n < loads; n++)
			queue_item(CMD_LOAD,
				$urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 65535),
				($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, cap));
		for (n = 0; n < grants; n++) begin
			if ($urandom_range(0, 7) == 0)
				queue_item(CMD_LOAD, $urandom_range(0, 15), $urandom_range(0, cap));
			queue_item(CMD_GRANT, $urandom, $urandom);
		end
		// Noise: any command with arbitrary fields.
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 3))
				queue_item(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 65535),
					$urandom_range(0, 65535));
	endtask

	// Waits until every queued word has gone in and every result has come
	// out, then lets the block settle. Polls on the falling edge, away from
	// the monitor's sampling.
	task automatic wait_drained();
		while (pending_words.size() != 0 || in_valid || expected_slices.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register writes happen only with the block idle, so the model takes the
	// new quantum as soon as the handshake completes.
	task automatic write_quantum(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_QUANTUM_ONE:   quantum_one = val;
			CFG_QUANTUM_TWO:   quantum_two = val;
			CFG_QUANTUM_THREE: quantum_three = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		@(posedge arst_n);

		// Directed part, at the reset quanta of 5, 8 and 16. An unused command
		// and a grant on an empty table come first.
		queue_item(CMD_NONE, 65535, 65535);
		queue_item(CMD_GRANT, 0, 0);
		queue_item(CMD_CLEAR, 0, 0);
		// Fill the table: a tie on arrival, a zero burst, both extremes of the
		// arrival time and the largest burst, then one load too many.
		queue_item(CMD_LOAD, 100, 3);
		queue_item(CMD_LOAD, 100, 0);
		queue_item(CMD_LOAD, 0, 20);
		queue_item(CMD_LOAD, 65535, 65535);
		queue_item(CMD_LOAD, 50, 12);
		queue_item(CMD_LOAD, 50, 1);
		queue_item(CMD_LOAD, 7, 30);
		queue_item(CMD_LOAD, 200, 9);
		queue_item(CMD_LOAD, 1, 1);
		repeat (6) queue_item(CMD_GRANT, 0, 0);
		// Loads during scheduling: one lands ahead of the scan position and
		// waits for the next pass, the other lands behind it.
		queue_item(CMD_CLEAR, 0, 0);
		queue_item(CMD_LOAD, 10, 40);
		queue_item(CMD_GRANT, 0, 0);
		queue_item(CMD_LOAD, 5, 4);
		queue_item(CMD_LOAD, 20, 2);
		repeat (3) queue_item(CMD_GRANT, 0, 0);
		wait_drained();

		// Smallest quanta, sender idling rarely and receiver often.
		write_quantum(CFG_QUANTUM_ONE, 16'd1);
		write_quantum(CFG_QUANTUM_TWO, 16'd1);
		write_quantum(CFG_QUANTUM_THREE, 16'd1);
		items_queued = 0;
		while (items_queued < 200)
			queue_schedule_run();
		wait_drained();

		// Largest quanta with full-range bursts, idling rates swapped.
		sender_idle_pct = 51;
		receiver_idle_pct = 7;
		write_quantum(CFG_QUANTUM_ONE, 16'hFFFF);
		write_quantum(CFG_QUANTUM_TWO, 16'hFFFF);
		write_quantum(CFG_QUANTUM_THREE, 16'hFFFF);
		items_queued = 0;
		while (items_queued < 200)
			queue_schedule_run();
		wait_drained();

		// A zero first quantum and small random ones for the other levels,
		// with no idling on either side.
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		write_quantum(CFG_QUANTUM_ONE, 16'd0);
		write_quantum(CFG_QUANTUM_TWO, DATA_W'($urandom_range(1, 20)));
		write_quantum(CFG_QUANTUM_THREE, DATA_W'($urandom_range(1, 40)));
		items_queued = 0;
		while (items_queued < 115)
			queue_schedule_run();
		// The receiver holds off while the sender keeps offering words, so the
		// block fills and stalls its input. The sender then stays quiet until
		// every result of this batch is back.
		hold_request = 1'b1;
		wait_drained();
		items_queued = 0;
		while (items_queued < 115)
			queue_schedule_run();
		wait_drained();

		if (failures == 0 && expected_slices.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
